### src/sensor_frame_crc4_deframer_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the CRC4 frame deframer
// Shared property shapes, clocked on clk with reset rst_n.
// ----------------------------------------------------------------------------
`ifndef SENSOR_FRAME_CRC4_DEFRAMER_MACROS_SVH
`define SENSOR_FRAME_CRC4_DEFRAMER_MACROS_SVH

// same-cycle implication
`define SFC4_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SFC4_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/sfc4_pkg.sv
// ----------------------------------------------------------------------------
// sfc4_pkg
// Types, constants and helpers shared by the CRC4 frame deframer.
// ----------------------------------------------------------------------------
package sfc4_pkg;

    localparam int MAX_FRAME_BYTES = 8;
    localparam int WIN_IDX_W       = $clog2(MAX_FRAME_BYTES);

    // nibble-wise CRC4 lookup
    localparam logic [3:0] CRC_TABLE [16] = '{
        4'd0, 4'd3, 4'd6, 4'd5, 4'd12, 4'd15, 4'd10, 4'd9,
        4'd11, 4'd8, 4'd13, 4'd14, 4'd7, 4'd4, 4'd1, 4'd2
    };

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CRC,
        ST_CHECK
    } sfc4_state_t;

    // command word to the shared CRC step unit
    typedef struct packed {
        logic       clear;
        logic       step;
        logic [3:0] nibble;
    } sfc4_crc_cmd_t;

    // frame length minus one for a channel count (0 acts as 1, 7 as 6)
    function automatic logic [WIN_IDX_W-1:0] frame_len_m1(input logic [2:0] chan);
        logic [WIN_IDX_W-1:0] len_m1;
        case (chan)
            3'd0, 3'd1: len_m1 = WIN_IDX_W'(2);
            3'd2:       len_m1 = WIN_IDX_W'(3);
            3'd3:       len_m1 = WIN_IDX_W'(5);
            3'd4:       len_m1 = WIN_IDX_W'(6);
            default:    len_m1 = WIN_IDX_W'(7);
        endcase
        return len_m1;
    endfunction

endpackage

### src/sensor_frame_crc4_deframer.sv
// ----------------------------------------------------------------------------
// sensor_frame_crc4_deframer
// CRC4-checked sensor frame deframer with byte-wise resync.
// ----------------------------------------------------------------------------
// Bytes enter one per cycle while in_stall is low. A byte that does not yet
// complete a frame is only shifted in. A byte that completes a frame of n bytes
// (n = 3, 4, 6, 7 or 8 from channel_count) starts a check that walks the
// window one nibble per cycle through a single shared CRC4 step unit; in_stall
// stays high through that walk and the final compare, and also while the
// finished word waits for the output register to empty. On a match
// the decoded word is loaded into the output register and the window is
// emptied; on a mismatch the oldest byte is dropped. Writing channel_count
// also empties the window; write it only while the block is idle.
// ----------------------------------------------------------------------------
module sensor_frame_crc4_deframer (
    input  logic       clk,
    input  logic       rst_n,
    // configuration
    input  logic       cfg_wr_en,
    input  logic [2:0] cfg_wr_data,
    // input bytes
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] data_byte,
    // decoded frames
    output logic       out_valid,
    input  logic       out_stall,
    output logic [3:0] sequence_number,
    output logic [3:0] digital_inputs,
    output logic [9:0] analog_first,
    output logic [9:0] analog_second,
    output logic [9:0] analog_third,
    output logic [9:0] analog_fourth,
    output logic [5:0] analog_fifth,
    output logic [5:0] analog_sixth
);
    import sfc4_pkg::*;

    // window: position 0 holds the newest byte
    logic [7:0]           win_reg [MAX_FRAME_BYTES];

    logic [2:0]           chan_reg;
    logic [WIN_IDX_W-1:0] fill_reg, fill_next;
    logic [WIN_IDX_W:0]   nib_reg, nib_next;
    sfc4_state_t          state_reg, state_next;
    logic                 out_valid_reg, out_valid_next;

    logic                 in_accept;
    logic                 shift_in;
    logic                 load_out;
    logic [WIN_IDX_W-1:0] len_m1;
    logic [WIN_IDX_W-1:0] rd_pos;
    logic [7:0]           rd_byte;
    logic                 last_nib;
    logic [3:0]           crc;
    sfc4_crc_cmd_t        crc_cmd;
    logic                 out_free;
    logic                 crc_pass;

    assign len_m1    = frame_len_m1(chan_reg);
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign crc_pass  = (crc == win_reg[0][3:0]);

    // nibble walk: oldest byte first, high nibble first, check nibble as zero
    assign rd_pos   = len_m1 - nib_reg[WIN_IDX_W:1];
    assign rd_byte  = win_reg[rd_pos];
    assign last_nib = (nib_reg[WIN_IDX_W:1] == len_m1) && nib_reg[0];

    sfc4_crc_unit u_crc (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (crc_cmd),
        .crc   (crc)
    );

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        nib_next       = nib_reg;
        out_valid_next = out_valid_reg;
        shift_in       = 1'b0;
        load_out       = 1'b0;
        crc_cmd.clear  = 1'b0;
        crc_cmd.step   = 1'b0;
        crc_cmd.nibble = 4'd0;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (cfg_wr_en)
                begin
                    // window restarts; a byte taken now becomes its first
                    fill_next = '0;
                    if (in_accept)
                    begin
                        shift_in  = 1'b1;
                        fill_next = WIN_IDX_W'(1);
                    end
                end
                else if (in_accept)
                begin
                    shift_in = 1'b1;
                    if (fill_reg == len_m1)
                    begin
                        crc_cmd.clear = 1'b1;
                        nib_next      = '0;
                        state_next    = ST_CRC;
                    end
                    else
                    begin
                        fill_next = fill_reg + 1'b1;
                    end
                end
            end
            ST_CRC:
            begin
                crc_cmd.step   = 1'b1;
                crc_cmd.nibble = last_nib ? 4'd0 :
                                 (nib_reg[0] ? rd_byte[3:0] : rd_byte[7:4]);
                nib_next       = nib_reg + 1'b1;
                if (last_nib)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (!crc_pass)
                begin
                    // oldest byte falls off: fill stays at n-1
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    load_out       = 1'b1;
                    out_valid_next = 1'b1;
                    fill_next      = '0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            nib_reg       <= '0;
            out_valid_reg <= 1'b0;
            chan_reg      <= 3'd6;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            nib_reg       <= nib_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                chan_reg <= cfg_wr_data;
            end
        end
    end

    // byte window shift line
    always_ff @(posedge clk)
    begin
        if (shift_in)
        begin
            win_reg[0] <= data_byte;
            for (int j = 1; j < MAX_FRAME_BYTES; j++)
            begin
                win_reg[j] <= win_reg[j-1];
            end
        end
    end

    // decoded word register
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            sequence_number <= win_reg[0][7:4];
            digital_inputs  <= win_reg[1][7:4];
            analog_first    <= {win_reg[1][3:0], win_reg[2][7:2]};
            analog_second   <= (chan_reg >= 3'd2) ? {win_reg[2][1:0], win_reg[3]} : 10'd0;
            analog_third    <= (chan_reg >= 3'd3) ? {win_reg[4], win_reg[5][7:6]} : 10'd0;
            analog_fourth   <= (chan_reg >= 3'd4) ? {win_reg[5][5:0], win_reg[6][7:4]}
                                                  : 10'd0;
            analog_fifth    <= (chan_reg >= 3'd5) ? {win_reg[6][3:0], win_reg[7][7:6]}
                                                  : 6'd0;
            analog_sixth    <= (chan_reg >= 3'd6) ? win_reg[7][5:0] : 6'd0;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

### src/sfc4_crc_unit.sv
// ----------------------------------------------------------------------------
// sfc4_crc_unit
// Shared CRC4 step unit: folds one nibble per cycle into a 4-bit remainder.
// ----------------------------------------------------------------------------
module sfc4_crc_unit (
    input  logic                   clk,
    input  logic                   rst_n,
    input  sfc4_pkg::sfc4_crc_cmd_t cmd,
    output logic [3:0]             crc
);
    import sfc4_pkg::*;

    logic [3:0] crc_reg;
    logic [3:0] crc_next;

    // table lookup then xor the incoming nibble
    always_comb
    begin
        crc_next = crc_reg;
        if (cmd.clear)
        begin
            crc_next = 4'd0;
        end
        else if (cmd.step)
        begin
            crc_next = CRC_TABLE[crc_reg] ^ cmd.nibble;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg <= 4'd0;
        end
        else
        begin
            crc_reg <= crc_next;
        end
    end

    assign crc = crc_reg;

endmodule

### src/sfc4_checker.sv
// ----------------------------------------------------------------------------
// sfc4_checker
// Port-level checks on the CRC4 frame deframer, bound to the top level.
// ----------------------------------------------------------------------------
`include "sensor_frame_crc4_deframer_macros.svh"

module sfc4_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       cfg_wr_en,
    input logic [2:0] cfg_wr_data,
    input logic       in_valid,
    input logic       in_stall,
    input logic [7:0] data_byte,
    input logic       out_valid,
    input logic       out_stall,
    input logic [3:0] sequence_number,
    input logic [3:0] digital_inputs,
    input logic [9:0] analog_first,
    input logic [9:0] analog_second,
    input logic [9:0] analog_third,
    input logic [9:0] analog_fourth,
    input logic [5:0] analog_fifth,
    input logic [5:0] analog_sixth
);

    // a stalled word holds
    `SFC4_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(sequence_number) && $stable(analog_first), "stalled output word changed")

    // a new word is only produced at the end of a busy check
    `SFC4_ASSERT_SAME(a_word_after_busy, $rose(out_valid), $past(in_stall), "output word appeared without a check")

    // a check walks several nibbles, so busy is still high in the cycle after it rises
    `SFC4_ASSERT_NEXT(a_busy_hold, $rose(in_stall), in_stall, "busy dropped right away")

    // the block only goes busy on a taken byte
    `SFC4_ASSERT_SAME(a_busy_on_byte, $rose(in_stall), $past(in_valid), "busy without an input byte")

endmodule

bind sensor_frame_crc4_deframer sfc4_checker u_sfc4_checker (.*);
